[src/bdi_pkg.sv]
`timescale 1ns / 1ps
// Package for the BDI line decompressor: command codes, mode decode and stage types.
// No dependencies.
package bdi_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int NUM_WORDS   = LINE_BYTES / 8;
    localparam int WIDX_W      = $clog2(NUM_WORDS);
    localparam int PACK_WORDS  = 5;
    localparam int STREAM_BITS = PACK_WORDS * 64;

    localparam logic [3:0] CMD_ZERO = 4'd0;
    localparam logic [3:0] CMD_REP  = 4'd1;
    localparam logic [3:0] CMD_B8D1 = 4'd2;
    localparam logic [3:0] CMD_B8D2 = 4'd3;
    localparam logic [3:0] CMD_B8D4 = 4'd4;
    localparam logic [3:0] CMD_B4D1 = 4'd5;
    localparam logic [3:0] CMD_B4D2 = 4'd6;
    localparam logic [3:0] CMD_B2D1 = 4'd7;

    typedef enum logic [1:0] {ESZ_NONE, ESZ_8, ESZ_4, ESZ_2} esz_t;
    typedef enum logic [1:0] {DSZ_0, DSZ_1, DSZ_2, DSZ_4} dsz_t;

    typedef struct packed {
        esz_t esz;
        dsz_t dsz;
        logic err;
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [WIDX_W-1:0] idx;
        logic              last;
        logic [31:0]       win;
        logic [3:0]        msk;
        logic [63:0]       base;
    } s1_t;

    typedef struct packed {
        logic [WIDX_W-1:0] idx;
        logic              last;
        logic              err;
        logic [63:0]       base;
        logic [63:0]       delta;
        logic [3:0]        msk;
        logic [3:1]        join_seg;
    } s2_t;

    function automatic mode_t decode_cmd(input logic [3:0] cmd);
        mode_t m;
        m = '{esz: ESZ_NONE, dsz: DSZ_0, err: 1'b0};
        case (cmd)
            CMD_ZERO: m.esz = ESZ_NONE;
            CMD_REP:  m.esz = ESZ_8;
            CMD_B8D1: begin m.esz = ESZ_8; m.dsz = DSZ_1; end
            CMD_B8D2: begin m.esz = ESZ_8; m.dsz = DSZ_2; end
            CMD_B8D4: begin m.esz = ESZ_8; m.dsz = DSZ_4; end
            CMD_B4D1: begin m.esz = ESZ_4; m.dsz = DSZ_1; end
            CMD_B4D2: begin m.esz = ESZ_4; m.dsz = DSZ_2; end
            CMD_B2D1: begin m.esz = ESZ_2; m.dsz = DSZ_1; end
            default:  m.err = 1'b1;
        endcase
        return m;
    endfunction

endpackage

[src/bdi_line_decompressor.sv]
`timescale 1ns / 1ps
// BDI cache line decompressor top level: line buffer, word sequencer and
// three-stage word pipeline. Depends on bdi_pkg.
//
// Usage:
//   Input channel s_*: one compressed line per transfer (command, zero mask,
//   40 packed bytes). Output channel m_*: eight 64-bit words per line,
//   word_index 0..7, last on word 7. Uncompressed or unknown commands give
//   a single word with status 1, zero data and last set.
//   Path: each word goes through the line buffer, stage 1, stage 2 and the
//   output register. Throughput: one word per cycle on the single word port
//   while m_ready is high; a line is eight words, an error line one.
//   A new line is taken as the last word issues; lines stream without gaps.
//   Stalls: with m_ready low the pipeline fills and holds; s_ready is high only
//   while the line buffer is empty or issuing its last word, so a stall holds
//   the sender off. Nothing is lost or repeated.
//   Reset: aresetn (synchronous, active low) clears all valid bits; the
//   block accepts a line in the first cycle after reset.
module bdi_line_decompressor
    import bdi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_command,
    input  logic [31:0]       s_zero_mask,
    input  logic [63:0]       s_packed_bytes_0,
    input  logic [63:0]       s_packed_bytes_1,
    input  logic [63:0]       s_packed_bytes_2,
    input  logic [63:0]       s_packed_bytes_3,
    input  logic [63:0]       s_packed_bytes_4,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_line_word,
    output logic [WIDX_W-1:0] m_word_index,
    output logic              m_status,
    output logic              m_last
);

    // line buffer and sequencer
    logic                   item_v_reg, item_v_next;
    logic [3:0]             item_cmd_reg, item_cmd_next;
    mode_t                  item_mode_reg, item_mode_next;
    logic [31:0]            item_mask_reg, item_mask_next;
    logic [STREAM_BITS-1:0] item_stream_reg, item_stream_next;
    logic [WIDX_W-1:0]      k_reg, k_next;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic [63:0]       word_reg, word_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic              status_reg, status_next;
    logic              last_reg, last_next;

    logic en1, en2, en3, issue, issue_last, accept;

    assign en3        = !v3_reg || m_ready;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign issue      = item_v_reg && en1;
    assign issue_last = issue && (item_mode_reg.err || k_reg == WIDX_W'(NUM_WORDS - 1));
    assign s_ready    = !item_v_reg || issue_last;
    assign accept     = s_valid && s_ready;

    always_comb begin
        item_v_next      = item_v_reg;
        item_cmd_next    = item_cmd_reg;
        item_mode_next   = item_mode_reg;
        item_mask_next   = item_mask_reg;
        item_stream_next = item_stream_reg;
        k_next           = k_reg;
        if (issue) begin
            k_next = issue_last ? '0 : k_reg + WIDX_W'(1);
        end
        if (issue_last) begin
            item_v_next = 1'b0;
        end
        if (accept) begin
            item_v_next      = 1'b1;
            item_cmd_next    = s_command;
            item_mode_next   = decode_cmd(s_command);
            item_mask_next   = s_zero_mask;
            item_stream_next = {s_packed_bytes_0, s_packed_bytes_1, s_packed_bytes_2,
                                s_packed_bytes_3, s_packed_bytes_4};
        end
    end

    // stage 1: delta window and mask bits of word k
    logic [5:0] off;
    logic [4:0] mi8, mi4, mi2;
    logic [8:0] win_top;

    always_comb begin
        case (item_cmd_reg)
            CMD_B8D1: off = 6'd8 + 6'(k_reg);
            CMD_B8D2: off = 6'd8 + {2'b00, k_reg, 1'b0};
            CMD_B8D4: off = 6'd8 + {1'b0, k_reg, 2'b00};
            CMD_B4D1: off = 6'd4 + {2'b00, k_reg, 1'b0};
            CMD_B4D2: off = 6'd4 + {1'b0, k_reg, 2'b00};
            CMD_B2D1: off = 6'd2 + {1'b0, k_reg, 2'b00};
            default:  off = 6'd0;
        endcase
        win_top = 9'(STREAM_BITS - 1) - {off, 3'b000};
        mi8     = 5'd7 - {2'b00, k_reg};
        mi4     = 5'd15 - {1'b0, k_reg, 1'b0};
        mi2     = 5'd31 - {k_reg, 2'b00};

        v1_next = v1_reg;
        s1_next = s1_reg;
        if (en1) begin
            v1_next      = issue;
            s1_next.mode = item_mode_reg;
            s1_next.idx  = item_mode_reg.err ? '0 : k_reg;
            s1_next.last = issue_last;
            s1_next.win  = item_stream_reg[win_top -: 32];
            s1_next.base = item_stream_reg[STREAM_BITS-1 -: 64];
            case (item_mode_reg.esz)
                ESZ_8:   s1_next.msk = {3'b000, item_mask_reg[mi8]};
                ESZ_4:   s1_next.msk = {2'b00, item_mask_reg[mi4 - 5'd1], item_mask_reg[mi4]};
                ESZ_2:   s1_next.msk = {item_mask_reg[mi2 - 5'd3], item_mask_reg[mi2 - 5'd2],
                                        item_mask_reg[mi2 - 5'd1], item_mask_reg[mi2]};
                default: s1_next.msk = '0;
            endcase
        end
    end

    // stage 2: sign-extend deltas into lanes, replicate base
    always_comb begin
        logic [31:0] w;
        logic [3:0]  m;
        logic [63:0] b;
        w = s1_reg.win;
        m = s1_reg.msk;
        b = s1_reg.base;
        v2_next = v2_reg;
        s2_next = s2_reg;
        if (en2) begin
            v2_next          = v1_reg;
            s2_next.idx      = s1_reg.idx;
            s2_next.last     = s1_reg.last;
            s2_next.err      = s1_reg.mode.err;
            s2_next.base     = '0;
            s2_next.delta    = '0;
            s2_next.msk      = '0;
            s2_next.join_seg = '0;
            if (!s1_reg.mode.err) begin
                case (s1_reg.mode.esz)
                    ESZ_8: begin
                        s2_next.base     = b;
                        s2_next.join_seg = 3'b111;
                        case (s1_reg.mode.dsz)
                            DSZ_1:   s2_next.delta = {{56{w[31]}}, w[31:24]};
                            DSZ_2:   s2_next.delta = {{48{w[31]}}, w[31:16]};
                            DSZ_4:   s2_next.delta = {{32{w[31]}}, w};
                            default: s2_next.delta = '0;
                        endcase
                        s2_next.msk = (s1_reg.mode.dsz == DSZ_0) ? 4'b0000 : {4{m[0]}};
                    end
                    ESZ_4: begin
                        s2_next.base     = {2{b[63:32]}};
                        s2_next.join_seg = 3'b101;
                        s2_next.msk      = {{2{m[1]}}, {2{m[0]}}};
                        if (s1_reg.mode.dsz == DSZ_2) begin
                            s2_next.delta = {{16{w[15]}}, w[15:0], {16{w[31]}}, w[31:16]};
                        end else begin
                            s2_next.delta = {{24{w[23]}}, w[23:16], {24{w[31]}}, w[31:24]};
                        end
                    end
                    ESZ_2: begin
                        s2_next.base  = {4{b[63:48]}};
                        s2_next.msk   = m;
                        s2_next.delta = {{8{w[7]}}, w[7:0], {8{w[15]}}, w[15:8],
                                         {8{w[23]}}, w[23:16], {8{w[31]}}, w[31:24]};
                    end
                    default: ;
                endcase
            end
        end
    end

    // stage 3: segmented add, zero-base select, output register
    always_comb begin
        logic [16:0] seg;
        logic        cy;
        v3_next     = v3_reg;
        word_next   = word_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        last_next   = last_reg;
        cy          = 1'b0;
        seg         = '0;
        if (en3) begin
            v3_next     = v2_reg;
            idx_next    = s2_reg.idx;
            status_next = s2_reg.err;
            last_next   = s2_reg.last;
            for (int i = 0; i < 4; i++) begin
                if (i > 0) begin
                    cy = s2_reg.join_seg[i] & seg[16];
                end
                seg = {1'b0, s2_reg.base[16*i +: 16]} + {1'b0, s2_reg.delta[16*i +: 16]}
                      + 17'(cy);
                word_next[16*i +: 16] = s2_reg.msk[i] ? s2_reg.delta[16*i +: 16] : seg[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_v_reg <= 1'b0;
            k_reg      <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end else begin
            item_v_reg <= item_v_next;
            k_reg      <= k_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_cmd_reg    <= item_cmd_next;
        item_mode_reg   <= item_mode_next;
        item_mask_reg   <= item_mask_next;
        item_stream_reg <= item_stream_next;
        s1_reg          <= s1_next;
        s2_reg          <= s2_next;
        word_reg        <= word_next;
        idx_reg         <= idx_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
    end

    assign m_valid      = v3_reg;
    assign m_line_word  = word_reg;
    assign m_word_index = idx_reg;
    assign m_status     = status_reg;
    assign m_last       = last_reg;

endmodule

[src/bdi_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the BDI line decompressor, bound to the top level.
// Depends on bdi_pkg.
module bdi_chk
    import bdi_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [63:0]       m_line_word,
    input logic [WIDX_W-1:0] m_word_index,
    input logic              m_status,
    input logic              m_last
);

    // error transfer is a lone, empty word
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last && m_word_index == '0 && m_line_word == '0)
        else $error("error transfer carries data or index");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_last == (m_word_index == WIDX_W'(NUM_WORDS - 1)))
        else $error("last flag not on final word");

    // words of a line leave back to back and in order
    a_word_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && !m_status && m_word_index == $past(m_word_index) + WIDX_W'(1))
        else $error("word sequence broken");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_word) && $stable(m_word_index)
            && $stable(m_status) && $stable(m_last))
        else $error("stalled transfer changed");

endmodule

bind bdi_line_decompressor bdi_chk u_bdi_chk (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for bdi_line_decompressor: directed table, then random lines with
// random gaps and back-pressure, each output word checked against queued expected words.
// Depends on bdi_pkg and the RTL in src.
module tb_top;
    import bdi_pkg::*;

    localparam logic [3:0]  CMD_RAW   = 4'd8;
    localparam logic [3:0]  CMD_TOP   = 4'd15;
    localparam int          RAND_LINES = 157;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 20;
    localparam logic [63:0] ALL1 = '1;
    localparam logic [63:0] P_A  = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] P_B  = 64'hFEDC_BA98_7654_3210;
    localparam logic [63:0] P_C  = 64'h7F80_01FF_8000_7FFF;
    localparam logic [63:0] P_D  = 64'h80FF_7F00_FF80_017F;

    typedef struct packed {
        logic [3:0]                       cmd;
        logic [31:0]                      mask;
        logic [0:PACK_WORDS-1][63:0]      pk;
    } cline_t;

    typedef struct packed {
        logic [63:0]       word;
        logic [WIDX_W-1:0] idx;
        logic              status;
        logic              last;
    } out_word_t;

    typedef struct packed {
        cline_t      li;
        logic        typed;
        logic        typed_err;
        logic [63:0] typed_word;
    } table_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [3:0]        s_command;
    logic [31:0]       s_zero_mask;
    logic [63:0]       s_packed_bytes_0;
    logic [63:0]       s_packed_bytes_1;
    logic [63:0]       s_packed_bytes_2;
    logic [63:0]       s_packed_bytes_3;
    logic [63:0]       s_packed_bytes_4;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [63:0]       m_line_word;
    logic [WIDX_W-1:0] m_word_index;
    logic              m_status;
    logic              m_last;

    out_word_t  pending_words[$];
    table_row_t line_table[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         rx_hold = 0;
    int         rx_cycle = 0;

    bdi_line_decompressor u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_zero_mask      (s_zero_mask),
        .s_packed_bytes_0 (s_packed_bytes_0),
        .s_packed_bytes_1 (s_packed_bytes_1),
        .s_packed_bytes_2 (s_packed_bytes_2),
        .s_packed_bytes_3 (s_packed_bytes_3),
        .s_packed_bytes_4 (s_packed_bytes_4),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_word      (m_line_word),
        .m_word_index     (m_word_index),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] stream_read(input logic [STREAM_BITS-1:0] strm,
                                                input int first, input int nbytes);
        logic [63:0] v;
        v = '0;
        for (int j = 0; j < nbytes; j++)
            v = {v[55:0], strm[STREAM_BITS-1-8*(first+j) -: 8]};
        return v;
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] v, input int nbytes);
        logic [63:0] r;
        r = v;
        for (int b = nbytes * 8; b < 64; b++)
            r[b] = v[nbytes*8-1];
        return r;
    endfunction

    // Rebuilds the line and queues the words it should leave as.
    task automatic expand_line(input cline_t li);
        logic [7:0]             line_b [LINE_BYTES];
        logic [STREAM_BITS-1:0] strm;
        logic [63:0]            base, delta, elem, w;
        int                     ebytes, dbytes, nelem;
        ebytes = 0;
        dbytes = 0;
        case (li.cmd)
            CMD_ZERO: ebytes = 0;
            CMD_REP:  ebytes = 8;
            CMD_B8D1: begin ebytes = 8; dbytes = 1; end
            CMD_B8D2: begin ebytes = 8; dbytes = 2; end
            CMD_B8D4: begin ebytes = 8; dbytes = 4; end
            CMD_B4D1: begin ebytes = 4; dbytes = 1; end
            CMD_B4D2: begin ebytes = 4; dbytes = 2; end
            CMD_B2D1: begin ebytes = 2; dbytes = 1; end
            default: begin
                pending_words.push_back('{word: '0, idx: '0, status: 1'b1, last: 1'b1});
                return;
            end
        endcase
        strm = li.pk;
        foreach (line_b[n]) line_b[n] = '0;
        if (ebytes != 0) begin
            nelem = LINE_BYTES / ebytes;
            base = stream_read(strm, 0, ebytes);
            for (int i = 0; i < nelem; i++) begin
                if (dbytes == 0) begin
                    elem = base;
                end else begin
                    delta = sign_extend(stream_read(strm, ebytes + i * dbytes, dbytes), dbytes);
                    elem = li.mask[nelem-1-i] ? delta : base + delta;
                end
                for (int b = 0; b < ebytes; b++)
                    line_b[i*ebytes+b] = elem[8*b +: 8];
            end
        end
        for (int k = 0; k < NUM_WORDS; k++) begin
            for (int b = 0; b < 8; b++)
                w[8*b +: 8] = line_b[8*k+b];
            pending_words.push_back('{word: w, idx: k[WIDX_W-1:0], status: 1'b0,
                                      last: (k == NUM_WORDS - 1)});
        end
    endtask

    task automatic add_row(input logic [3:0] c, input logic [31:0] m,
                           input logic [0:PACK_WORDS-1][63:0] pk,
                           input logic typed, input logic terr, input logic [63:0] tw);
        line_table.push_back('{li: '{cmd: c, mask: m, pk: pk},
                               typed: typed, typed_err: terr, typed_word: tw});
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic cline_t random_line();
        cline_t li;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 6)       li.cmd = CMD_ZERO;
        else if (r < 12) li.cmd = CMD_REP;
        else if (r < 88) li.cmd = 4'($urandom_range(CMD_B8D1, CMD_B2D1));
        else             li.cmd = 4'($urandom_range(CMD_RAW, CMD_TOP));
        r = $urandom_range(0, 9);
        li.mask = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        for (int w = 0; w < PACK_WORDS; w++)
            li.pk[w] = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) li.pk[0] = ALL1;
        return li;
    endfunction

    // Called at a falling edge; returns at the rising edge of the transfer.
    task automatic drive_line(input cline_t li);
        s_valid          <= 1'b1;
        s_command        <= li.cmd;
        s_zero_mask      <= li.mask;
        s_packed_bytes_0 <= li.pk[0];
        s_packed_bytes_1 <= li.pk[1];
        s_packed_bytes_2 <= li.pk[2];
        s_packed_bytes_3 <= li.pk[3];
        s_packed_bytes_4 <= li.pk[4];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pace_sender(input bit drain, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        @(negedge aclk);
        if (drain || gap > 0) s_valid <= 1'b0;
        repeat (gap) @(negedge aclk);
        if (drain)
            while (pending_words.size() != 0) @(negedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (((rx_cycle / 256) % 3 != 2) && ($urandom_range(0, 99) < 25)) begin
            m_ready <= 1'b0;
            rx_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 40);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                flag_mismatch("unexpected transfer, word", m_line_word, '0);
            end else begin
                want = pending_words.pop_front();
                if (m_line_word !== want.word)
                    flag_mismatch("line_word", m_line_word, want.word);
                if (m_word_index !== want.idx)
                    flag_mismatch("word_index", 64'(m_word_index), 64'(want.idx));
                if (m_status !== want.status)
                    flag_mismatch("status", 64'(m_status), 64'(want.status));
                if (m_last !== want.last)
                    flag_mismatch("last", 64'(m_last), 64'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_command        = '0;
        s_zero_mask      = '0;
        s_packed_bytes_0 = '0;
        s_packed_bytes_1 = '0;
        s_packed_bytes_2 = '0;
        s_packed_bytes_3 = '0;
        s_packed_bytes_4 = '0;

        // zero and repeat lines, then each base-delta mode, then error encodings
        add_row(CMD_ZERO, '0, {5{64'h0}}, 1'b1, 1'b0, '0);
        add_row(CMD_ZERO, '1, {5{ALL1}}, 1'b1, 1'b0, '0);
        add_row(CMD_REP, '0, {ALL1, {4{64'h0}}}, 1'b1, 1'b0, ALL1);
        add_row(CMD_REP, '1, {P_A, {4{ALL1}}}, 1'b1, 1'b0, P_A);
        add_row(CMD_B8D1, '0, {P_A, P_C, P_D, P_B, ALL1}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D1, '1, {P_A, P_C, P_D, P_B, ALL1}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D1, '0, {5{ALL1}}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D1, 32'hFFFF_FF5A, {P_B, P_D, {3{P_C}}}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D1, '0, {5{64'h0}}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D2, '0, {ALL1, P_C, P_D, P_A, P_B}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D2, 32'h0000_00A5, {P_C, P_D, P_C, P_D, P_A}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D4, '0, {P_B, P_C, P_D, P_A, P_C}, 1'b0, 1'b0, '0);
        add_row(CMD_B8D4, '1, {P_A, P_D, P_C, P_D, P_C}, 1'b0, 1'b0, '0);
        add_row(CMD_B4D1, '0, {P_C, P_D, P_A, P_B, ALL1}, 1'b0, 1'b0, '0);
        add_row(CMD_B4D1, 32'hFFFF_C3C3, {ALL1, P_C, P_D, P_C, P_D}, 1'b0, 1'b0, '0);
        add_row(CMD_B4D2, '0, {P_D, P_C, P_D, P_C, P_B}, 1'b0, 1'b0, '0);
        add_row(CMD_B4D2, 32'h0000_5A5A, {P_A, P_C, P_D, P_B, P_C}, 1'b0, 1'b0, '0);
        add_row(CMD_B2D1, '0, {P_C, P_D, P_C, P_D, P_A}, 1'b0, 1'b0, '0);
        add_row(CMD_B2D1, '1, {P_D, P_C, P_D, P_C, P_B}, 1'b0, 1'b0, '0);
        add_row(CMD_B2D1, 32'h8000_0001, {ALL1, P_D, P_A, P_C, P_D}, 1'b0, 1'b0, '0);
        add_row(CMD_RAW, '0, {5{64'h0}}, 1'b1, 1'b1, '0);
        add_row(CMD_TOP, '1, {5{ALL1}}, 1'b1, 1'b1, '0);
        add_row(4'd9, 32'h1234_5678, {P_A, P_B, P_C, P_D, P_A}, 1'b1, 1'b1, '0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (line_table[r]) begin
            drive_line(line_table[r].li);
            if (!line_table[r].typed) begin
                expand_line(line_table[r].li);
            end else if (line_table[r].typed_err) begin
                pending_words.push_back('{word: '0, idx: '0, status: 1'b1, last: 1'b1});
            end else begin
                for (int k = 0; k < NUM_WORDS; k++)
                    pending_words.push_back('{word: line_table[r].typed_word,
                                              idx: k[WIDX_W-1:0], status: 1'b0,
                                              last: (k == NUM_WORDS - 1)});
            end
            pace_sender(r == line_table.size() - 1, 1'b0);
        end

        for (int n = 0; n < RAND_LINES; n++) begin
            cline_t li;
            li = random_line();
            drive_line(li);
            expand_line(li);
            pace_sender(n == RAND_LINES / 2, (n >= 40 && n < 70) || (n >= 130 && n < 150));
        end

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
